### hdl/gwtf_pkg.sv
package gwtf_pkg;

  localparam int SUM_W = 40;
  localparam int CNT_W = 8;
  localparam int STAMP_W = 63;
  localparam int DIV_STEPS = SUM_W / 2;
  localparam int STEP_W = $clog2(DIV_STEPS);

  localparam logic [CNT_W-1:0] MAX_SAMPLES = CNT_W'(255);
  localparam logic OPC_WHEEL = 1'b0;
  localparam logic OPC_GYRO = 1'b1;

  localparam int REG_TIMEOUT = 0;
  localparam int REG_THRESH = 1;

  localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef struct packed {
    logic [31:0] timeout_us;
    logic [30:0] stop_threshold;
  } cfg_t;

  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [CNT_W-1:0] wn;
    logic [CNT_W-1:0] gn;
    logic signed [SUM_W-1:0] vx_sum;
    logic signed [SUM_W-1:0] vvar_sum;
    logic signed [SUM_W-1:0] wx_sum;
    logic signed [SUM_W-1:0] wy_sum;
    logic signed [SUM_W-1:0] wz_sum;
    logic signed [SUM_W-1:0] gvar_sum;
  } job_t;

endpackage

### hdl/gwtf_if.sv
interface gwtf_in_if;
  logic valid;
  logic ready;
  logic opcode;
  logic [62:0] stamp_us;
  logic [31:0] age_us;
  logic signed [31:0] vx;
  logic signed [31:0] vx_var;
  logic signed [31:0] gx;
  logic signed [31:0] gy;
  logic signed [31:0] gz;
  logic signed [31:0] gyro_var_x;
  logic signed [31:0] gyro_var_y;
  logic signed [31:0] gyro_var_z;

  modport source (output valid, opcode, stamp_us, age_us, vx, vx_var, gx, gy, gz,
                  gyro_var_x, gyro_var_y, gyro_var_z, input ready);
  modport sink (input valid, opcode, stamp_us, age_us, vx, vx_var, gx, gy, gz,
                gyro_var_x, gyro_var_y, gyro_var_z, output ready);
endinterface

interface gwtf_out_if;
  logic valid;
  logic ready;
  logic [62:0] fused_stamp_us;
  logic signed [31:0] vx_mean;
  logic [30:0] vx_var_out;
  logic signed [31:0] wx_mean;
  logic signed [31:0] wy_mean;
  logic signed [31:0] wz_mean;
  logic [30:0] w_var_out;
  logic stopped;

  modport source (output valid, fused_stamp_us, vx_mean, vx_var_out, wx_mean, wy_mean,
                  wz_mean, w_var_out, stopped, input ready);
  modport sink (input valid, fused_stamp_us, vx_mean, vx_var_out, wx_mean, wy_mean,
                wz_mean, w_var_out, stopped, output ready);
endinterface

### hdl/gyro_wheel_twist_fuser.sv
// Fuses wheel forward speed with gyro angular rates into one twist word.
// Input words arrive on in_ch with opcode selecting a wheel or a gyro sample;
// an input word is taken whenever valid and ready are both high. Fused words
// leave on out_ch under the same valid/ready rule.
// The front end updates the running sums in the cycle a word is taken, so it
// accepts one word per cycle as long as its two-entry job queue has room.
// A word that completes a fusion pushes a snapshot of the sums into the queue.
// The back end divides six sums by their counts in parallel lanes, two
// quotient bits per cycle, then divides both variance lanes by the count
// again. The back end pops the next job only once it is idle again, after
// the fused word of the current job has gone into the output register.
// When out_ch stalls the result holds in the output register, the back end
// waits with the next result, and the queue then fills and drops in_ch.ready.
// Reset (rst, synchronous) clears all sums, counts and seen flags and loads
// timeout_us = 200000 and stop_threshold = 655. The APB port holds timeout_us
// at address 0 and stop_threshold at address 4; write them while idle.
module gyro_wheel_twist_fuser (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  gwtf_in_if.sink in_ch,
  gwtf_out_if.source out_ch
);
  import gwtf_pkg::*;

  cfg_t cfg;
  job_t wr_job, rd_job;
  logic push, pop, q_full, q_valid;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? {1'b0, cfg.stop_threshold} : cfg.timeout_us;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_us <= 32'd200000;
      cfg.stop_threshold <= 31'd655;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2]) cfg.stop_threshold <= pwdata[30:0];
      else cfg.timeout_us <= pwdata;
    end
  end

  gwtf_front u_front (
    .clk(clk), .rst(rst), .cfg(cfg), .in_ch(in_ch),
    .q_full(q_full), .push(push), .job(wr_job)
  );

  gwtf_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .wr_job(wr_job), .full(q_full),
    .pop(pop), .valid(q_valid), .rd_job(rd_job)
  );

  gwtf_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .job_valid(q_valid), .job(rd_job),
    .pop(pop), .out_ch(out_ch)
  );
endmodule

### hdl/gwtf_front.sv
module gwtf_front (
  input  logic clk,
  input  logic rst,
  input  gwtf_pkg::cfg_t cfg,
  gwtf_in_if.sink in_ch,
  input  logic q_full,
  output logic push,
  output gwtf_pkg::job_t job
);
  import gwtf_pkg::*;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [31:0] b);
    logic signed [SUM_W:0] r;
    r = $signed({a[SUM_W-1], a}) + $signed({{(SUM_W-31){b[31]}}, b});
    if (r > $signed({1'b0, SUM_MAX})) return SUM_MAX;
    if (r < $signed({1'b1, SUM_MIN})) return SUM_MIN;
    return r[SUM_W-1:0];
  endfunction

  logic wheel_seen, wheel_seen_next, gyro_seen, gyro_seen_next;
  logic [CNT_W-1:0] wn, wn_upd, gn, gn_upd;
  logic [SUM_W-1:0] vx_sum, vx_sum_upd, vvar_sum, vvar_sum_upd, gvar_sum, gvar_sum_upd;
  logic [SUM_W-1:0] wx_sum, wx_sum_upd, wy_sum, wy_sum_upd, wz_sum, wz_sum_upd;
  logic [STAMP_W-1:0] wstamp, wstamp_upd, gstamp, gstamp_upd;
  logic fire, stale, clear;
  logic [31:0] m;

  assign in_ch.ready = !q_full;
  assign fire = in_ch.valid && in_ch.ready;
  assign stale = in_ch.age_us > cfg.timeout_us;

  always_comb begin
    m = 32'd0;
    if ($signed(in_ch.gyro_var_x) > $signed(m)) m = in_ch.gyro_var_x;
    if ($signed(in_ch.gyro_var_y) > $signed(m)) m = in_ch.gyro_var_y;
    if ($signed(in_ch.gyro_var_z) > $signed(m)) m = in_ch.gyro_var_z;
  end

  always_comb begin
    wheel_seen_next = wheel_seen;
    gyro_seen_next = gyro_seen;
    wn_upd = wn;
    gn_upd = gn;
    vx_sum_upd = vx_sum;
    vvar_sum_upd = vvar_sum;
    wx_sum_upd = wx_sum;
    wy_sum_upd = wy_sum;
    wz_sum_upd = wz_sum;
    gvar_sum_upd = gvar_sum;
    wstamp_upd = wstamp;
    gstamp_upd = gstamp;
    clear = 1'b0;
    push = 1'b0;
    if (fire) begin
      if (in_ch.opcode == OPC_WHEEL) begin
        wheel_seen_next = 1'b1;
        if (gyro_seen) begin
          if (stale) begin
            clear = 1'b1;
          end else if (wn < MAX_SAMPLES) begin
            vx_sum_upd = sat_add(vx_sum, in_ch.vx);
            vvar_sum_upd = sat_add(vvar_sum, in_ch.vx_var);
            wstamp_upd = in_ch.stamp_us;
            wn_upd = wn + 1'b1;
            if (gn != '0) begin
              push = 1'b1;
              clear = 1'b1;
            end
          end
        end
      end else begin
        gyro_seen_next = 1'b1;
        if (!wheel_seen || stale) begin
          clear = 1'b1;
        end else if (gn < MAX_SAMPLES) begin
          wx_sum_upd = sat_add(wx_sum, in_ch.gx);
          wy_sum_upd = sat_add(wy_sum, in_ch.gy);
          wz_sum_upd = sat_add(wz_sum, in_ch.gz);
          gvar_sum_upd = sat_add(gvar_sum, m);
          gstamp_upd = in_ch.stamp_us;
          gn_upd = gn + 1'b1;
          if (wn != '0) begin
            push = 1'b1;
            clear = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    job.stamp = (wstamp_upd < gstamp_upd) ? gstamp_upd : wstamp_upd;
    job.wn = wn_upd;
    job.gn = gn_upd;
    job.vx_sum = vx_sum_upd;
    job.vvar_sum = vvar_sum_upd;
    job.wx_sum = wx_sum_upd;
    job.wy_sum = wy_sum_upd;
    job.wz_sum = wz_sum_upd;
    job.gvar_sum = gvar_sum_upd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_seen <= 1'b0;
      gyro_seen <= 1'b0;
      wn <= '0;
      gn <= '0;
      vx_sum <= '0;
      vvar_sum <= '0;
      wx_sum <= '0;
      wy_sum <= '0;
      wz_sum <= '0;
      gvar_sum <= '0;
      wstamp <= '0;
      gstamp <= '0;
    end else begin
      wheel_seen <= wheel_seen_next;
      gyro_seen <= gyro_seen_next;
      if (clear) begin
        wn <= '0;
        gn <= '0;
        vx_sum <= '0;
        vvar_sum <= '0;
        wx_sum <= '0;
        wy_sum <= '0;
        wz_sum <= '0;
        gvar_sum <= '0;
        wstamp <= '0;
        gstamp <= '0;
      end else begin
        wn <= wn_upd;
        gn <= gn_upd;
        vx_sum <= vx_sum_upd;
        vvar_sum <= vvar_sum_upd;
        wx_sum <= wx_sum_upd;
        wy_sum <= wy_sum_upd;
        wz_sum <= wz_sum_upd;
        gvar_sum <= gvar_sum_upd;
        wstamp <= wstamp_upd;
        gstamp <= gstamp_upd;
      end
    end
  end
endmodule

### hdl/gwtf_queue.sv
module gwtf_queue (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  gwtf_pkg::job_t wr_job,
  output logic full,
  input  logic pop,
  output logic valid,
  output gwtf_pkg::job_t rd_job
);
  import gwtf_pkg::*;

  job_t slots [2];
  logic wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full = count == 2'd2;
  assign valid = count != 2'd0;
  assign rd_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

### hdl/gwtf_back.sv
module gwtf_back (
  input  logic clk,
  input  logic rst,
  input  gwtf_pkg::cfg_t cfg,
  input  logic job_valid,
  input  gwtf_pkg::job_t job,
  output logic pop,
  gwtf_out_if.source out_ch
);
  import gwtf_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV1 = 2'd1;
  localparam logic [1:0] S_DIV2 = 2'd2;
  localparam logic [1:0] S_FIN = 2'd3;
  localparam int LANES = 6;
  localparam int L_VX = 0;
  localparam int L_VVAR = 1;
  localparam int L_WX = 2;
  localparam int L_WY = 3;
  localparam int L_WZ = 4;
  localparam int L_GVAR = 5;

  function automatic logic [CNT_W+SUM_W-1:0] div_step2(input logic [CNT_W-1:0] r,
                                                       input logic [SUM_W-1:0] q,
                                                       input logic [CNT_W-1:0] d);
    logic [CNT_W:0] t;
    logic [CNT_W-1:0] rr;
    logic [SUM_W-1:0] qq;
    logic ge;
    rr = r;
    qq = q;
    for (int k = 0; k < 2; k++) begin
      t = {rr, qq[SUM_W-1]};
      ge = t >= {1'b0, d};
      qq = {qq[SUM_W-2:0], ge};
      if (ge) t = t - {1'b0, d};
      rr = t[CNT_W-1:0];
    end
    return {rr, qq};
  endfunction

  function automatic logic [SUM_W-1:0] mag(input logic [SUM_W-1:0] s);
    return s[SUM_W-1] ? -s : s;
  endfunction

  function automatic logic [31:0] mean_out(input logic [SUM_W-1:0] q, input logic n);
    if (n) return (q > SUM_W'(33'h80000000)) ? 32'h80000000 : -q[31:0];
    return (q > SUM_W'(32'h7fffffff)) ? 32'h7fffffff : q[31:0];
  endfunction

  function automatic logic [31:0] mean_abs(input logic [SUM_W-1:0] q, input logic n);
    if (n) return (q > SUM_W'(33'h80000000)) ? 32'h80000000 : q[31:0];
    return (q > SUM_W'(32'h7fffffff)) ? 32'h7fffffff : q[31:0];
  endfunction

  function automatic logic [30:0] var_res(input logic [SUM_W-1:0] q, input logic n);
    if (n) return '0;
    return (q > SUM_W'(31'h7fffffff)) ? 31'h7fffffff : q[30:0];
  endfunction

  logic [1:0] state;
  logic [STEP_W-1:0] step;
  logic [CNT_W-1:0] rem [LANES];
  logic [SUM_W-1:0] quo [LANES];
  logic [CNT_W+SUM_W-1:0] nxt [LANES];
  logic neg [LANES];
  logic [CNT_W-1:0] wn, gn;
  logic [STAMP_W-1:0] stamp;
  logic [SUM_W-1:0] sums [LANES];
  logic last, emit;

  assign sums[L_VX] = job.vx_sum;
  assign sums[L_VVAR] = job.vvar_sum;
  assign sums[L_WX] = job.wx_sum;
  assign sums[L_WY] = job.wy_sum;
  assign sums[L_WZ] = job.wz_sum;
  assign sums[L_GVAR] = job.gvar_sum;

  assign last = step == STEP_W'(DIV_STEPS - 1);
  assign pop = state == S_IDLE && job_valid;
  assign emit = state == S_FIN && (!out_ch.valid || out_ch.ready);

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      nxt[i] = div_step2(rem[i], quo[i], (i < L_WX) ? wn : gn);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      if (emit) out_ch.valid <= 1'b1;
      else if (out_ch.ready) out_ch.valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          step <= '0;
          if (job_valid) state <= S_DIV1;
        end
        S_DIV1: begin
          step <= last ? '0 : step + 1'b1;
          if (last) state <= S_DIV2;
        end
        S_DIV2: begin
          step <= last ? '0 : step + 1'b1;
          if (last) state <= S_FIN;
        end
        S_FIN: begin
          if (emit) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        wn <= job.wn;
        gn <= job.gn;
        stamp <= job.stamp;
        for (int i = 0; i < LANES; i++) begin
          rem[i] <= '0;
          quo[i] <= mag(sums[i]);
          neg[i] <= sums[i][SUM_W-1];
        end
      end
      S_DIV1: begin
        for (int i = 0; i < LANES; i++) begin
          quo[i] <= nxt[i][SUM_W-1:0];
          rem[i] <= (last && (i == L_VVAR || i == L_GVAR)) ? '0 : nxt[i][CNT_W+SUM_W-1:SUM_W];
        end
      end
      S_DIV2: begin
        quo[L_VVAR] <= nxt[L_VVAR][SUM_W-1:0];
        rem[L_VVAR] <= nxt[L_VVAR][CNT_W+SUM_W-1:SUM_W];
        quo[L_GVAR] <= nxt[L_GVAR][SUM_W-1:0];
        rem[L_GVAR] <= nxt[L_GVAR][CNT_W+SUM_W-1:SUM_W];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_ch.fused_stamp_us <= stamp;
      out_ch.vx_mean <= mean_out(quo[L_VX], neg[L_VX]);
      out_ch.vx_var_out <= var_res(quo[L_VVAR], neg[L_VVAR]);
      out_ch.wx_mean <= mean_out(quo[L_WX], neg[L_WX]);
      out_ch.wy_mean <= mean_out(quo[L_WY], neg[L_WY]);
      out_ch.wz_mean <= mean_out(quo[L_WZ], neg[L_WZ]);
      out_ch.w_var_out <= var_res(quo[L_GVAR], neg[L_GVAR]);
      out_ch.stopped <= mean_abs(quo[L_WZ], neg[L_WZ]) < {1'b0, cfg.stop_threshold} &&
                        mean_abs(quo[L_VX], neg[L_VX]) < {1'b0, cfg.stop_threshold};
    end
  end
endmodule
